/* rtl/core/sha256_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package sha256_pkg;

  localparam int BlockBytes = 64;
  localparam int Rounds     = 64;

  typedef logic [31:0] word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } core_state_t;

  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       eom;
  } fifo_item_t;

  function automatic word_t iv_word(input logic [2:0] i);
    word_t r;
    unique case (i)
      3'd0: r = 32'h6a09e667;
      3'd1: r = 32'hbb67ae85;
      3'd2: r = 32'h3c6ef372;
      3'd3: r = 32'ha54ff53a;
      3'd4: r = 32'h510e527f;
      3'd5: r = 32'h9b05688c;
      3'd6: r = 32'h1f83d9ab;
      default: r = 32'h5be0cd19;
    endcase
    return r;
  endfunction

  function automatic word_t round_k(input logic [5:0] i);
    word_t r;
    unique case (i)
      6'd0: r = 32'h428a2f98; 6'd1: r = 32'h71374491; 6'd2: r = 32'hb5c0fbcf;
      6'd3: r = 32'he9b5dba5; 6'd4: r = 32'h3956c25b; 6'd5: r = 32'h59f111f1;
      6'd6: r = 32'h923f82a4; 6'd7: r = 32'hab1c5ed5; 6'd8: r = 32'hd807aa98;
      6'd9: r = 32'h12835b01; 6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
      6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe; 6'd14: r = 32'h9bdc06a7;
      6'd15: r = 32'hc19bf174; 6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
      6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc; 6'd20: r = 32'h2de92c6f;
      6'd21: r = 32'h4a7484aa; 6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
      6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d; 6'd26: r = 32'hb00327c8;
      6'd27: r = 32'hbf597fc7; 6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
      6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967; 6'd32: r = 32'h27b70a85;
      6'd33: r = 32'h2e1b2138; 6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
      6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb; 6'd38: r = 32'h81c2c92e;
      6'd39: r = 32'h92722c85; 6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
      6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3; 6'd44: r = 32'hd192e819;
      6'd45: r = 32'hd6990624; 6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
      6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08; 6'd50: r = 32'h2748774c;
      6'd51: r = 32'h34b0bcb5; 6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
      6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3; 6'd56: r = 32'h748f82ee;
      6'd57: r = 32'h78a5636f; 6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
      6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb; 6'd62: r = 32'hbef9a3f7;
      default: r = 32'hc67178f2;
    endcase
    return r;
  endfunction

  function automatic word_t rotr(input word_t x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage
`default_nettype wire

/* rtl/core/sha256_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// Input word queue between the handshake and the compression engine.
module sha256_front
  import sha256_pkg::*;
#(
  parameter int Depth = 4
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  output logic            full,
  input  wire fifo_item_t wr_item,
  input  wire logic       rd_en,
  output logic            rd_valid,
  output fifo_item_t      rd_item
);
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  fifo_item_t        mem [Depth];
  logic [AW-1:0]     wp_r, rp_r;
  logic [AW:0]       cnt_r;
  logic              wr, rd;

  assign full     = (cnt_r == (AW+1)'(Depth));
  assign rd_valid = (cnt_r != '0);
  assign wr       = push && !full;
  assign rd       = rd_en && rd_valid;
  assign rd_item  = mem[rp_r];

  function automatic logic [AW-1:0] inc(input logic [AW-1:0] p);
    return (p == AW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wp_r] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= inc(wp_r);
      if (rd) rp_r <= inc(rp_r);
      cnt_r <= cnt_r + (AW+1)'(wr) - (AW+1)'(rd);
    end
  end
endmodule
`default_nettype wire

/* rtl/core/sha256_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// Block buffer, padding, 64-round compression and digest output.
module sha256_back
  import sha256_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       item_valid,
  input  wire fifo_item_t item,
  output logic            item_take,
  output logic            out_empty,
  input  wire logic       out_pop,
  output logic [31:0]     out_digest_word,
  output logic [2:0]      out_word_index,
  output logic            out_last_word
);
  // message bytes as 16 big-endian words, written one byte a cycle while the engine is idle
  word_t        blk_r [16];
  word_t        w_r [16];
  word_t        v_r [8];
  word_t        h_r [8];
  logic [5:0]   fill_r;
  logic [63:0]  bits_r;
  logic [63:0]  total_r;
  logic [5:0]   rnd_r;
  logic [2:0]   oidx_r;
  logic         fin_r;      // compressing because of end of message
  logic         pad2_r;     // second padding block still due
  logic         eomq_r;     // message end still to be handled after a byte
  core_state_t  st_r, st_nxt;

  // padding pass: pos = fill; build block for a final compression
  logic         do_byte, do_end, blk_full;
  logic [63:0]  total_nxt;
  word_t        w_new, s0, s1, t1, t2, big0, big1, ch, mj;

  assign do_byte = (st_r == ST_IDLE) && item_valid && item.has_byte && !eomq_r;
  assign blk_full = do_byte && (fill_r == 6'd63);
  assign total_nxt = bits_r + {55'd0, fill_r, 3'd0};

  always_comb begin
    s0   = rotr(w_r[1], 7) ^ rotr(w_r[1], 18) ^ (w_r[1] >> 3);
    s1   = rotr(w_r[14], 17) ^ rotr(w_r[14], 19) ^ (w_r[14] >> 10);
    w_new = s1 + w_r[9] + s0 + w_r[0];
    big1 = rotr(v_r[4], 6) ^ rotr(v_r[4], 11) ^ rotr(v_r[4], 25);
    ch   = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    t1   = v_r[7] + big1 + ch + round_k(rnd_r) + w_r[0];
    big0 = rotr(v_r[0], 2) ^ rotr(v_r[0], 13) ^ rotr(v_r[0], 22);
    mj   = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t2   = big0 + mj;
  end

  // end handled in IDLE when no byte pending in this item
  assign do_end = (st_r == ST_IDLE) && item_valid &&
                  (eomq_r || (item.eom && !item.has_byte));

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE:  if (blk_full || do_end) st_nxt = ST_LOAD;
      ST_LOAD:  st_nxt = ST_ROUND;
      ST_ROUND: if (rnd_r == 6'd63) st_nxt = ST_ADD;
      ST_ADD:   st_nxt = (fin_r && !pad2_r) ? ST_EMIT
                       : (pad2_r ? ST_LOAD : ST_IDLE);
      ST_EMIT:  if (out_pop && oidx_r == 3'd7) st_nxt = ST_IDLE;
      default:  st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    item_take = 1'b0;
    if (st_r == ST_IDLE && item_valid) begin
      if (do_end) item_take = 1'b1;
      else if (do_byte && !item.eom && !blk_full) item_take = 1'b1;
      // word with neither byte nor end is dropped
      else if (!item.has_byte && !item.eom) item_take = 1'b1;
    end
    // a full block without end is taken when its compression finishes
    if (st_r == ST_ADD && !fin_r && !eomq_r) item_take = 1'b1;
  end

  assign out_empty       = (st_r != ST_EMIT);
  assign out_digest_word = h_r[oidx_r];
  assign out_word_index  = oidx_r;
  assign out_last_word   = (oidx_r == 3'd7);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      fill_r <= '0;
      bits_r <= '0;
      rnd_r  <= '0;
      oidx_r <= '0;
      fin_r  <= 1'b0;
      pad2_r <= 1'b0;
      eomq_r <= 1'b0;
      for (int i = 0; i < 8; i++) h_r[i] <= iv_word(3'(i));
    end else begin
      st_r <= st_nxt;
      unique case (st_r)
        ST_IDLE: begin
          if (do_byte) begin
            fill_r <= fill_r + 6'd1;
            if (item.eom && !blk_full) eomq_r <= 1'b1;
            if (blk_full) begin
              fin_r  <= 1'b0;
              eomq_r <= item.eom;
            end
          end else if (do_end) begin
            // pad the partial block in place
            eomq_r  <= 1'b0;
            fin_r   <= 1'b1;
            total_r <= total_nxt;
            pad2_r  <= (fill_r > 6'd55);
          end
        end
        ST_LOAD: begin
          rnd_r <= '0;
        end
        ST_ROUND: begin
          rnd_r <= rnd_r + 6'd1;
        end
        ST_ADD: begin
          for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
          if (!fin_r) bits_r <= bits_r + 64'd512;
          if (pad2_r) pad2_r <= 1'b0;
          if (!fin_r) fill_r <= '0;
          oidx_r <= '0;
        end
        ST_EMIT: begin
          if (out_pop) begin
            oidx_r <= oidx_r + 3'd1;
            if (oidx_r == 3'd7) begin
              for (int i = 0; i < 8; i++) h_r[i] <= iv_word(3'(i));
              fill_r <= '0;
              bits_r <= '0;
              fin_r  <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // block words and schedule window
  always_ff @(posedge clk) begin
    if (do_byte) begin
      blk_r[fill_r[5:2]][8*(3-fill_r[1:0]) +: 8] <= item.data;
    end else if (do_end || (st_r == ST_ADD && pad2_r)) begin
      for (int j = 0; j < 16; j++) begin
        if (st_r == ST_ADD) begin
          // second padding block: zeros and length only
          blk_r[j] <= (j == 14) ? total_r[63:32] : (j == 15) ? total_r[31:0] : '0;
        end else begin
          for (int b = 0; b < 4; b++) begin
            if (4*j + b < int'(fill_r)) begin
              blk_r[j][8*(3-b) +: 8] <= blk_r[j][8*(3-b) +: 8];
            end else if (4*j + b == int'(fill_r)) begin
              blk_r[j][8*(3-b) +: 8] <= 8'h80;
            end else if (j >= 14 && fill_r <= 6'd55) begin
              blk_r[j][8*(3-b) +: 8] <= 8'(total_nxt >> (8*(7 - (4*(j-14) + b))));
            end else begin
              blk_r[j][8*(3-b) +: 8] <= 8'h00;
            end
          end
        end
      end
    end
    if (st_r == ST_LOAD) begin
      for (int j = 0; j < 16; j++) w_r[j] <= blk_r[j];
      for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
    end else if (st_r == ST_ROUND) begin
      for (int j = 0; j < 15; j++) w_r[j] <= w_r[j+1];
      w_r[15] <= w_new;
      v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2]; v_r[2] <= v_r[1]; v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
  end
endmodule
`default_nettype wire

/* rtl/core/sha256_stream_hasher.sv */
`timescale 1ns / 1ps
`default_nettype none
// channel  | handshake     | word
// in       | push / full   | in_data_byte, in_has_byte, in_end_of_message
// out      | empty / pop   | out_digest_word, out_word_index, out_last_word
// The engine takes byte words while idle; the 64th byte of a block starts
// a compression (load, 64 rounds on one round unit, add).
// End of message costs one or two compressions, then eight digest words.
// A short input queue holds words while the engine compresses.
// Synchronous active-low reset restores the initial hash value.
module sha256_stream_hasher
  import sha256_pkg::*;
#(
  parameter int QueueDepth = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_has_byte,
  input  wire logic        in_end_of_message,
  output logic             empty,
  input  wire logic        pop,
  output logic [31:0]      out_digest_word,
  output logic [2:0]       out_word_index,
  output logic             out_last_word
);
  fifo_item_t wr_item, rd_item;
  logic       rd_valid, rd_en;

  assign wr_item = '{data: in_data_byte, has_byte: in_has_byte, eom: in_end_of_message};

  sha256_front #(.Depth(QueueDepth)) u_front (
    .clk, .rst_n, .push, .full, .wr_item,
    .rd_en, .rd_valid, .rd_item
  );

  sha256_back u_back (
    .clk, .rst_n,
    .item_valid(rd_valid), .item(rd_item), .item_take(rd_en),
    .out_empty(empty), .out_pop(pop),
    .out_digest_word, .out_word_index, .out_last_word
  );
endmodule
`default_nettype wire

/* dv/sha256_stream_hasher_tb.sv */
`timescale 1ns / 1ps
module sha256_stream_hasher_tb;
  import sha256_pkg::*;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
  } byte_word_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_out_t;

  localparam int StallLimit = 4000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        pop = 1'b0;
  logic [7:0]  in_data_byte = '0;
  logic        in_has_byte = 1'b0;
  logic        in_end_of_message = 1'b0;
  logic        full, empty;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;

  sha256_stream_hasher uut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .in_data_byte(in_data_byte), .in_has_byte(in_has_byte),
    .in_end_of_message(in_end_of_message), .empty(empty), .pop(pop),
    .out_digest_word(out_digest_word), .out_word_index(out_word_index),
    .out_last_word(out_last_word)
  );

  always #5 clk = ~clk;

  byte_word_t  pending_words[$];
  digest_out_t digest_expect[$];
  bit          failed = 0;
  bit          stim_done = 0;
  int          idle_cycles = 0;

  // hasher state mirror
  logic [31:0] hash_h[8];
  logic [7:0]  blk[64];
  int          fill;
  logic [63:0] bit_count;

  localparam logic [31:0] RoundConst[64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
  localparam logic [31:0] InitHash[8] = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372,
    32'ha54ff53a, 32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  function automatic logic [31:0] ror(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress();
    logic [31:0] w[64];
    logic [31:0] v[8];
    logic [31:0] t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    for (int i = 16; i < 64; i++)
      w[i] = (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
           + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
    v = hash_h;
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundConst[i] + w[i];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_h[i] += v[i];
  endtask

  task automatic hash_word(byte_word_t bw);
    int pos;
    logic [63:0] total;
    if (bw.has_byte) begin
      blk[fill] = bw.data_byte;
      fill++;
      if (fill == 64) begin
        compress();
        bit_count += 64'd512;
        fill = 0;
      end
    end
    if (bw.end_of_message) begin
      pos = fill;
      total = bit_count + 64'(pos) * 8;
      blk[pos] = 8'h80;
      pos++;
      if (pos > 56) begin
        while (pos < 64) begin
          blk[pos] = 8'h00;
          pos++;
        end
        compress();
        pos = 0;
      end
      while (pos < 56) begin
        blk[pos] = 8'h00;
        pos++;
      end
      for (int k = 0; k < 8; k++) blk[56+k] = total[63-8*k -: 8];
      compress();
      for (int k = 0; k < 8; k++)
        digest_expect.push_back('{hash_h[k], 3'(k), k == 7});
      hash_h = InitHash;
      fill = 0;
      bit_count = '0;
    end
  endtask

  task automatic add_message(int len, bit end_with_byte);
    for (int i = 0; i < len; i++)
      pending_words.push_back('{8'($urandom), 1'b1,
                               end_with_byte && (i == len - 1)});
    if (!end_with_byte || len == 0)
      pending_words.push_back('{8'($urandom), 1'b0, 1'b1});
  endtask

  // driver
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst_n && !stim_done) begin
      if (push && !full) begin
        hash_word({in_data_byte, in_has_byte, in_end_of_message});
        send_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
        if ($urandom_range(0, 2) == 0) send_gap = 0;
      end
      if (!push || !full) begin
        if (send_gap > 0) begin
          send_gap--;
          push <= 1'b0;
        end else if (pending_words.size() > 0) begin
          byte_word_t bw;
          bw = pending_words.pop_front();
          push <= 1'b1;
          {in_data_byte, in_has_byte, in_end_of_message} <= bw;
        end else begin
          push <= 1'b0;
          stim_done <= 1'b1;
        end
      end
    end
  end

  // monitor
  int recv_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (pop && !empty) begin
        if (digest_expect.size() == 0) begin
          $error("unexpected digest word %h", out_digest_word);
          failed = 1;
        end else begin
          digest_out_t exp_w;
          exp_w = digest_expect.pop_front();
          if (out_digest_word !== exp_w.digest_word) begin
            $error("digest_word exp %h got %h", exp_w.digest_word, out_digest_word);
            failed = 1;
          end
          if (out_word_index !== exp_w.word_index) begin
            $error("word_index exp %0d got %0d", exp_w.word_index, out_word_index);
            failed = 1;
          end
          if (out_last_word !== exp_w.last_word) begin
            $error("last_word exp %0d got %0d", exp_w.last_word, out_last_word);
            failed = 1;
          end
        end
        recv_gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 8);
      end
      if (!pop || !empty) begin
        if (recv_gap > 0) begin
          recv_gap--;
          pop <= 1'b0;
        end else begin
          pop <= 1'b1;
        end
      end
      if ((push && !full) || (pop && !empty)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    hash_h = InitHash;
    fill = 0;
    bit_count = '0;
    foreach (blk[i]) blk[i] = '0;
    // directed: empty message, "abc", full and near-full block ends
    add_message(0, 0);
    pending_words.push_back('{8'h61, 1'b1, 1'b0});
    pending_words.push_back('{8'h62, 1'b1, 1'b0});
    pending_words.push_back('{8'h63, 1'b1, 1'b1});
    pending_words.push_back('{8'h00, 1'b1, 1'b0});
    pending_words.push_back('{8'hff, 1'b1, 1'b1});
    pending_words.push_back('{8'haa, 1'b0, 1'b0}); // ignored byte
    pending_words.push_back('{8'h55, 1'b1, 1'b0});
    pending_words.push_back('{8'h00, 1'b0, 1'b1});
    add_message(55, 1);
    add_message(56, 0);
    add_message(64, 1);
    add_message(64, 0);
    while (pending_words.size() < 450) begin
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) pending_words.push_back('{8'($urandom), 1'b0, 1'b0});
      else if (r < 3) add_message($urandom_range(0, 130), $urandom_range(0, 1));
      else add_message($urandom_range(0, 20), $urandom_range(0, 1));
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    wait (stim_done && digest_expect.size() == 0);
    repeat (200) @(posedge clk);
    if (failed || digest_expect.size() != 0) $display("status: fail");
    else $display("status: pass");
    $finish;
  end
endmodule
